// ===== rtl/hbppg_pkg.sv =====
`timescale 1ns / 1ps

package hbppg_pkg;

	localparam int POS_W       = 10;
	localparam int DUR_W       = 11;
	localparam int DIV_W       = 16;
	localparam int FLAGS_W     = 4;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int WORD_W      = 32;
	localparam int RESET_OFFSET = 'h10;
	localparam int PIN_MASK     = 16;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ARM_FLAGS     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_DELAY     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_DURATION  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_DIVIDER   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_DELAY    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_DURATION = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_DIVIDER  = 3'd6;

	// arm_flags bits
	localparam int FLAG_LOW_EN   = 0;
	localparam int FLAG_HIGH_EN  = 1;
	localparam int FLAG_LOW_CHOP = 2;
	localparam int FLAG_HIGH_CHOP = 3;

	typedef struct packed {
		logic             enable;
		logic             chopper;
		logic [POS_W-1:0] delay;
		logic [DUR_W-1:0] duration;
		logic [DIV_W-1:0] divider;
	} arm_cfg_t;

	typedef struct packed {
		logic             act;
		logic             on;
		logic             active;
		logic [DIV_W-1:0] count;
	} arm_res_t;

endpackage

// ===== rtl/hbppg_arm.sv =====
`timescale 1ns / 1ps

module hbppg_arm (
	input  logic [hbppg_pkg::POS_W-1:0] pos,
	input  hbppg_pkg::arm_cfg_t         cfg,
	input  logic                        other_active,
	input  logic [hbppg_pkg::DIV_W-1:0] count,
	input  logic                        active,
	output hbppg_pkg::arm_res_t         res
);

	logic [hbppg_pkg::DUR_W:0] win_end;
	logic                      in_window;

	assign win_end   = {2'b00, cfg.delay} + {1'b0, cfg.duration};
	assign in_window = (pos >= cfg.delay) && ({2'b00, pos} < win_end);

	always_comb begin
		res.act    = 1'b0;
		res.on     = 1'b0;
		res.active = active;
		res.count  = count;
		if (cfg.enable && !other_active) begin
			res.act = 1'b1;
			if (in_window) begin
				if (cfg.chopper) begin
					if (count < cfg.divider) begin
						res.on     = 1'b1;
						res.active = 1'b1;
						res.count  = count + 16'd1;
					end else begin
						res.active = ~active;
						res.count  = '0;
					end
				end else begin
					res.on     = 1'b1;
					res.active = 1'b1;
				end
			end else begin
				res.active = 1'b0;
			end
		end
	end

endmodule

// ===== rtl/half_bridge_pulse_pattern_generator_unit.sv =====
`timescale 1ns / 1ps
// channel   signals                          payload
// request   req_valid / req_ready            position
// response  rsp_valid / rsp_ready            drive_word, low_on, high_on
// config    cfg_wr_en                        cfg_index, cfg_data
//
// One word per clock sustained while rsp_ready stays high. Position reduction
// runs in stages s1 and s2, arm evaluation and state update in stage s3, the
// last stage before the output register that drives rsp_valid.
// arst_n clears configuration, arm counters and on-flags, and all valids.
// A stalled response holds the pipeline only as far back as bubbles allow.

module half_bridge_pulse_pattern_generator_unit #(
	parameter int PATTERN_LEN = 1024,
	parameter int LOW_PIN     = 0,
	parameter int HIGH_PIN    = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [hbppg_pkg::POS_W-1:0]       position,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [hbppg_pkg::WORD_W-1:0]      drive_word,
	output logic                              low_on,
	output logic                              high_on,
	input  logic                              cfg_wr_en,
	input  logic [hbppg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hbppg_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int LP = LOW_PIN % hbppg_pkg::PIN_MASK;
	localparam int HP = HIGH_PIN % hbppg_pkg::PIN_MASK;
	localparam int SH_W = 27;
	localparam logic [SH_W-1:0] LEN = SH_W'(PATTERN_LEN);

	logic [hbppg_pkg::FLAGS_W-1:0] arm_flags_q;
	logic [hbppg_pkg::POS_W-1:0]   low_delay_q, high_delay_q;
	logic [hbppg_pkg::DUR_W-1:0]   low_duration_q, high_duration_q;
	logic [hbppg_pkg::DIV_W-1:0]   low_divider_q, high_divider_q;

	logic [hbppg_pkg::DIV_W-1:0]   low_step_count_q, high_step_count_q;
	logic                          low_active_q, high_active_q;

	logic                          v_s1, v_s2, v_s3, out_valid_q;
	logic [hbppg_pkg::POS_W-1:0]   pos_s1, pos_s2, pos_s3;
	logic [hbppg_pkg::POS_W-1:0]   red_hi, red_lo;
	logic                          rdy1, rdy2, rdy3, adv3;

	hbppg_pkg::arm_cfg_t           low_cfg, high_cfg;
	hbppg_pkg::arm_res_t           low_res, high_res;
	logic [hbppg_pkg::WORD_W-1:0]  word;

	logic [hbppg_pkg::WORD_W-1:0]  drive_word_q;
	logic                          low_on_q, high_on_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_flags_q     <= '0;
			low_delay_q     <= '0;
			low_duration_q  <= '0;
			low_divider_q   <= '0;
			high_delay_q    <= '0;
			high_duration_q <= '0;
			high_divider_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				hbppg_pkg::REG_ARM_FLAGS:
					arm_flags_q <= cfg_data[hbppg_pkg::FLAGS_W-1:0];
				hbppg_pkg::REG_LOW_DELAY:
					low_delay_q <= cfg_data[hbppg_pkg::POS_W-1:0];
				hbppg_pkg::REG_LOW_DURATION:
					low_duration_q <= cfg_data[hbppg_pkg::DUR_W-1:0];
				hbppg_pkg::REG_LOW_DIVIDER:
					low_divider_q <= cfg_data[hbppg_pkg::DIV_W-1:0];
				hbppg_pkg::REG_HIGH_DELAY:
					high_delay_q <= cfg_data[hbppg_pkg::POS_W-1:0];
				hbppg_pkg::REG_HIGH_DURATION:
					high_duration_q <= cfg_data[hbppg_pkg::DUR_W-1:0];
				hbppg_pkg::REG_HIGH_DIVIDER:
					high_divider_q <= cfg_data[hbppg_pkg::DIV_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline flow
	assign rdy3      = !v_s3 || !out_valid_q || rsp_ready;
	assign adv3      = v_s3 && rdy3;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign req_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)
				v_s1 <= req_valid;
			if (rdy2)
				v_s2 <= v_s1;
			if (rdy3)
				v_s3 <= v_s2;
			if (adv3)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	// position modulo pattern length, restoring reduction split over two stages
	always_comb begin
		logic [SH_W-1:0] sh;
		red_hi = pos_s1;
		for (int k = 9; k >= 5; k--) begin
			sh = LEN << k;
			if ({{(SH_W-hbppg_pkg::POS_W){1'b0}}, red_hi} >= sh)
				red_hi = red_hi - sh[hbppg_pkg::POS_W-1:0];
		end
	end

	always_comb begin
		logic [SH_W-1:0] sh;
		red_lo = pos_s2;
		for (int k = 4; k >= 0; k--) begin
			sh = LEN << k;
			if ({{(SH_W-hbppg_pkg::POS_W){1'b0}}, red_lo} >= sh)
				red_lo = red_lo - sh[hbppg_pkg::POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && rdy1)
			pos_s1 <= position;
		if (v_s1 && rdy2)
			pos_s2 <= red_hi;
		if (v_s2 && rdy3)
			pos_s3 <= red_lo;
	end

	// arm evaluation, low arm first
	assign low_cfg.enable    = arm_flags_q[hbppg_pkg::FLAG_LOW_EN];
	assign low_cfg.chopper   = arm_flags_q[hbppg_pkg::FLAG_LOW_CHOP];
	assign low_cfg.delay     = low_delay_q;
	assign low_cfg.duration  = low_duration_q;
	assign low_cfg.divider   = low_divider_q;
	assign high_cfg.enable   = arm_flags_q[hbppg_pkg::FLAG_HIGH_EN];
	assign high_cfg.chopper  = arm_flags_q[hbppg_pkg::FLAG_HIGH_CHOP];
	assign high_cfg.delay    = high_delay_q;
	assign high_cfg.duration = high_duration_q;
	assign high_cfg.divider  = high_divider_q;

	hbppg_arm u_low_arm (
		.pos          (pos_s3),
		.cfg          (low_cfg),
		.other_active (high_active_q),
		.count        (low_step_count_q),
		.active       (low_active_q),
		.res          (low_res)
	);

	hbppg_arm u_high_arm (
		.pos          (pos_s3),
		.cfg          (high_cfg),
		.other_active (low_res.active),
		.count        (high_step_count_q),
		.active       (high_active_q),
		.res          (high_res)
	);

	always_comb begin
		word = '0;
		word[LP + hbppg_pkg::RESET_OFFSET] = 1'b1;
		word[HP + hbppg_pkg::RESET_OFFSET] = 1'b1;
		if (low_res.on) begin
			word[LP]                           = 1'b1;
			word[LP + hbppg_pkg::RESET_OFFSET] = 1'b0;
		end
		if (high_res.act) begin
			word[HP]                           = high_res.on;
			word[HP + hbppg_pkg::RESET_OFFSET] = ~high_res.on;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_step_count_q  <= '0;
			high_step_count_q <= '0;
			low_active_q      <= 1'b0;
			high_active_q     <= 1'b0;
		end else if (adv3) begin
			low_step_count_q  <= low_res.count;
			high_step_count_q <= high_res.count;
			low_active_q      <= low_res.active;
			high_active_q     <= high_res.active;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			drive_word_q <= word;
			low_on_q     <= low_res.on;
			high_on_q    <= high_res.on;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign drive_word = drive_word_q;
	assign low_on     = low_on_q;
	assign high_on    = high_on_q;

`ifndef NO_ASSERTIONS
	a_arms_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(low_active_q && high_active_q))
		else $error("both arm on-flags set");

	a_on_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(low_on && high_on))
		else $error("both arms driven on in one word");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv3 |=> ($stable(low_step_count_q) && $stable(high_step_count_q)))
		else $error("arm state changed without a word leaving the last stage");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> v_s1)
		else $error("accepted word lost at the input stage");
`endif

endmodule

// ===== tb/sv/half_bridge_pulse_pattern_generator_unit_tb.sv =====
`timescale 1ns / 1ps

module half_bridge_pulse_pattern_generator_unit_tb;
	import hbppg_pkg::*;

	localparam int PATTERN_LEN = 1024;
	localparam int LOW_PIN     = 0;
	localparam int HIGH_PIN    = 1;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 8;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic              low_on;
		logic              high_on;
	} drive_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   req_valid = 1'b0;
	logic                   req_ready;
	logic [POS_W-1:0]       position = '0;
	logic                   rsp_valid;
	logic                   rsp_ready = 1'b0;
	logic [WORD_W-1:0]      drive_word;
	logic                   low_on;
	logic                   high_on;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// register mirror
	logic [FLAGS_W-1:0] arm_flags = '0;
	logic [POS_W-1:0]   low_delay = '0, high_delay = '0;
	logic [DUR_W-1:0]   low_duration = '0, high_duration = '0;
	logic [DIV_W-1:0]   low_divider = '0, high_divider = '0;

	// arm state
	logic [DIV_W-1:0] low_count = '0, high_count = '0;
	logic             low_act = 1'b0, high_act = 1'b0;

	drive_t expected_drives[$];
	int     fail_count = 0;
	int     cycles = 0;
	logic   idle_en = 1'b1;
	int     hold_seq = 0;
	int     hold_seen = 0;
	int     hold_left = 0;

	half_bridge_pulse_pattern_generator_unit #(
		.PATTERN_LEN(PATTERN_LEN),
		.LOW_PIN(LOW_PIN),
		.HIGH_PIN(HIGH_PIN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.position(position),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.drive_word(drive_word),
		.low_on(low_on),
		.high_on(high_on),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic arm_decide(input logic [POS_W-1:0] pos, input int pin, input logic en,
		input logic chop, input logic other, input logic [POS_W-1:0] dly,
		input logic [DUR_W-1:0] dur, input logic [DIV_W-1:0] div,
		inout logic [DIV_W-1:0] cnt, inout logic act, inout logic [WORD_W-1:0] word,
		output logic on);
		int lim;
		on = 1'b0;
		lim = int'(dly) + int'(dur);
		if (en && !other) begin
			if (pos >= dly && int'(pos) < lim) begin
				if (chop && cnt >= div) begin
					act = ~act;
					cnt = '0;
				end else begin
					on = 1'b1;
					act = 1'b1;
					if (chop)
						cnt = cnt + 1'b1;
				end
			end else begin
				act = 1'b0;
			end
			word[pin] = on;
			word[pin + RESET_OFFSET] = ~on;
		end
	endtask

	task automatic predict_drive(input logic [POS_W-1:0] pos);
		drive_t d;
		logic [POS_W-1:0] p;
		p = POS_W'(int'(pos) % PATTERN_LEN);
		d.word = '0;
		d.word[LOW_PIN + RESET_OFFSET] = 1'b1;
		d.word[HIGH_PIN + RESET_OFFSET] = 1'b1;
		arm_decide(p, LOW_PIN, arm_flags[FLAG_LOW_EN], arm_flags[FLAG_LOW_CHOP], high_act,
			low_delay, low_duration, low_divider, low_count, low_act, d.word, d.low_on);
		arm_decide(p, HIGH_PIN, arm_flags[FLAG_HIGH_EN], arm_flags[FLAG_HIGH_CHOP], low_act,
			high_delay, high_duration, high_divider, high_count, high_act, d.word, d.high_on);
		expected_drives.push_back(d);
	endtask

	// response check and receiver pacing
	always @(posedge clk) begin
		drive_t exp;
		if (rsp_valid && rsp_ready) begin
			if (expected_drives.size() == 0) begin
				$error("unexpected word: drive_word %h low_on %b high_on %b",
					drive_word, low_on, high_on);
				fail_count++;
			end else begin
				exp = expected_drives.pop_front();
				if (drive_word !== exp.word) begin
					$error("drive_word: expected %h, got %h", exp.word, drive_word);
					fail_count++;
				end
				if (low_on !== exp.low_on) begin
					$error("low_on: expected %b, got %b", exp.low_on, low_on);
					fail_count++;
				end
				if (high_on !== exp.high_on) begin
					$error("high_on: expected %b, got %b", exp.high_on, high_on);
					fail_count++;
				end
			end
		end
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= !(idle_en && $urandom_range(99) < 6);
		end
	end

	task automatic send_position(input logic [POS_W-1:0] pos);
		if (idle_en && $urandom_range(99) < 6) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		position <= pos;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predict_drive(pos);
	endtask

	task automatic settle;
		req_valid <= 1'b0;
		while (expected_drives.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_ARM_FLAGS:     arm_flags = val[FLAGS_W-1:0];
			REG_LOW_DELAY:     low_delay = val[POS_W-1:0];
			REG_LOW_DURATION:  low_duration = val[DUR_W-1:0];
			REG_LOW_DIVIDER:   low_divider = val[DIV_W-1:0];
			REG_HIGH_DELAY:    high_delay = val[POS_W-1:0];
			REG_HIGH_DURATION: high_duration = val[DUR_W-1:0];
			REG_HIGH_DIVIDER:  high_divider = val[DIV_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [15:0] flags, input logic [15:0] ldly,
		input logic [15:0] ldur, input logic [15:0] ldiv, input logic [15:0] hdly,
		input logic [15:0] hdur, input logic [15:0] hdiv);
		settle();
		put_reg(REG_ARM_FLAGS, flags);
		put_reg(REG_LOW_DELAY, ldly);
		put_reg(REG_LOW_DURATION, ldur);
		put_reg(REG_LOW_DIVIDER, ldiv);
		put_reg(REG_HIGH_DELAY, hdly);
		put_reg(REG_HIGH_DURATION, hdur);
		put_reg(REG_HIGH_DIVIDER, hdiv);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [15:0] pick_delay;
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'd1023;
			2: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(0, 1023));
		endcase
	endfunction

	function automatic logic [15:0] pick_duration;
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'd1024;
			2: return 16'($urandom_range(0, 65535));
			3: return 16'($urandom_range(0, 1024));
			default: return 16'($urandom_range(1, 400));
		endcase
	endfunction

	function automatic logic [15:0] pick_divider;
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'd65535;
			2: return 16'($urandom_range(0, 65535));
			default: return 16'($urandom_range(1, 6));
		endcase
	endfunction

	task automatic random_setup;
		configure(16'($urandom_range(0, 65535)) | (($urandom_range(0, 3) != 0) ? 16'h3 : 16'h0),
			pick_delay(), pick_duration(), pick_divider(),
			pick_delay(), pick_duration(), pick_divider());
	endtask

	task automatic test_reset_state;
		send_position(10'd0);
		send_position(10'd1023);
	endtask

	task automatic test_plain_windows;
		configure(16'h3, 16'd10, 16'd10, 16'd0, 16'd30, 16'd10, 16'd0);
		send_position(10'd9);
		send_position(10'd10);
		send_position(10'd19);
		send_position(10'd20);
		send_position(10'd30);
		send_position(10'd39);
	endtask

	// overlapping windows: whichever arm holds its on-flag locks the other out
	task automatic test_interlock;
		configure(16'h3, 16'd100, 16'd100, 16'd0, 16'd150, 16'd100, 16'd0);
		send_position(10'd150);
		send_position(10'd200);
		send_position(10'd160);
	endtask

	task automatic test_window_extremes;
		configure(16'h3, 16'd1023, 16'd1024, 16'd0, 16'd0, 16'd0, 16'd0);
		send_position(10'd1023);
		send_position(10'd0);
	endtask

	task automatic test_chopper;
		configure(16'h5, 16'd0, 16'd1024, 16'd2, 16'd0, 16'd0, 16'd0);
		for (int i = 0; i < 6; i++)
			send_position(POS_W'(i));
		// zero divider: every in-window step is an off step
		configure(16'hA, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1024, 16'd0);
		for (int i = 0; i < 3; i++)
			send_position(POS_W'(i + 500));
	endtask

	// only the low bits of the flags, delay and duration registers are kept
	task automatic test_wide_writes;
		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_position(10'd1023);
		send_position(10'd0);
	endtask

	task automatic test_output_stall;
		configure(16'hF, 16'd0, 16'd600, 16'd3, 16'd300, 16'd700, 16'd2);
		idle_en <= 1'b0;
		hold_seq <= hold_seq + 1;
		for (int i = 0; i < 60; i++)
			send_position(POS_W'(i * 7));
		settle();
		idle_en <= 1'b1;
	endtask

	task automatic test_random_patterns;
		logic [POS_W-1:0] start;
		int sweep;
		for (int ph = 0; ph < 30; ph++) begin
			random_setup();
			idle_en <= !(ph >= 12 && ph < 20);
			start = POS_W'($urandom_range(0, 1023));
			sweep = ($urandom_range(0, 9) < 6);
			for (int i = 0; i < 50; i++) begin
				if (sweep)
					send_position(start + POS_W'(i));
				else
					send_position(POS_W'($urandom_range(0, 1023)));
			end
		end
		idle_en <= 1'b1;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_plain_windows();
		test_interlock();
		test_window_extremes();
		test_chopper();
		test_wide_writes();
		test_output_stall();
		test_random_patterns();
		settle();
		if (fail_count == 0 && expected_drives.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/hbppg_pkg.sv
rtl/hbppg_arm.sv
rtl/half_bridge_pulse_pattern_generator_unit.sv
tb/sv/half_bridge_pulse_pattern_generator_unit_tb.sv
